/* src/shell_line_tokenizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shell line tokenizer
// Immediate-implication and next-cycle checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slt assertion failed");
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slt assertion failed");
`else
`define SLT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/slt_pkg.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer package
// Scan modes, token kinds, character codes and the queue entry format.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 4;
    localparam logic [7:0]  DEF_ARG_SLOTS   = 8'd64;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_WORD_ESC,
        MODE_DQ,
        MODE_DQ_ESC,
        MODE_SQ,
        MODE_SQ_ESC,
        MODE_GT,
        MODE_DROP
    } t_scan_mode;

    typedef enum logic [2:0] {
        KIND_WORD,
        KIND_PIPE,
        KIND_IN,
        KIND_OUT,
        KIND_APPEND
    } t_token_kind;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        has_char;
        logic        token_end;
        t_token_kind token_kind;
    } t_result;

    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
        logic    eol;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_result mk_blank();
        t_result r;
        r.out_char   = 8'd0;
        r.has_char   = 1'b0;
        r.token_end  = 1'b0;
        r.token_kind = KIND_WORD;
        return r;
    endfunction

    function automatic t_result mk_char(input logic [7:0] c);
        t_result r;
        r          = mk_blank();
        r.out_char = c;
        r.has_char = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_end(input t_token_kind k);
        t_result r;
        r            = mk_blank();
        r.token_end  = 1'b1;
        r.token_kind = k;
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

/* src/slt_front.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer front end
// Accepts bytes, tracks scan mode and token count, and queues up to two
// results per byte.
// ----------------------------------------------------------------------------
module slt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_char,
    input  logic              i_end_of_line,
    output logic              o_in_stall,
    input  slt_pkg::t_q_status i_q_status,
    output logic              o_push,
    output slt_pkg::t_entry   o_entry
);
    import slt_pkg::*;

    t_scan_mode  r_mode,  n_mode;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_arg_slots;

    logic        accept;
    logic [1:0]  nres;

    // outcome of a byte seen between tokens
    t_scan_mode  idle_mode;
    logic        idle_inc;
    logic        idle_has;
    t_result     idle_res;
    logic        at_limit;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign at_limit   = ({1'b0, r_count} + 9'd1) >= {1'b0, r_arg_slots};

    always_comb begin
        idle_mode = MODE_IDLE;
        idle_inc  = 1'b0;
        idle_has  = 1'b0;
        idle_res  = mk_blank();
        if (!is_blank(i_in_char)) begin
            if (at_limit) begin
                idle_mode = MODE_DROP;
            end else begin
                idle_inc = 1'b1;
                case (i_in_char)
                    CH_PIPE: begin
                        idle_has = 1'b1;
                        idle_res = mk_end(KIND_PIPE);
                    end
                    CH_LT: begin
                        idle_has = 1'b1;
                        idle_res = mk_end(KIND_IN);
                    end
                    CH_GT:     idle_mode = MODE_GT;
                    CH_DQUOTE: idle_mode = MODE_DQ;
                    CH_SQUOTE: idle_mode = MODE_SQ;
                    CH_BSLASH: idle_mode = MODE_WORD_ESC;
                    default: begin
                        idle_has  = 1'b1;
                        idle_res  = mk_char(i_in_char);
                        idle_mode = MODE_WORD;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        nres          = 2'd0;
        o_entry.res0  = mk_blank();
        o_entry.res1  = mk_blank();
        o_entry.eol   = i_end_of_line;
        if (i_end_of_line) begin
            n_mode  = MODE_IDLE;
            n_count = 8'd0;
            nres    = 2'd1;
            case (r_mode)
                MODE_WORD, MODE_DQ, MODE_SQ: o_entry.res0 = mk_end(KIND_WORD);
                MODE_WORD_ESC, MODE_DQ_ESC, MODE_SQ_ESC: begin
                    o_entry.res0 = mk_char(CH_BSLASH);
                    o_entry.res1 = mk_end(KIND_WORD);
                    nres         = 2'd2;
                end
                MODE_GT: o_entry.res0 = mk_end(KIND_OUT);
                default: o_entry.res0 = mk_blank();
            endcase
        end else begin
            case (r_mode)
                MODE_WORD: begin
                    if (is_blank(i_in_char)) begin
                        o_entry.res0 = mk_end(KIND_WORD);
                        nres         = 2'd1;
                        n_mode       = MODE_IDLE;
                    end else if (i_in_char == CH_PIPE || i_in_char == CH_LT ||
                                 i_in_char == CH_GT) begin
                        o_entry.res0 = mk_end(KIND_WORD);
                        o_entry.res1 = idle_res;
                        nres         = idle_has ? 2'd2 : 2'd1;
                        n_mode       = idle_mode;
                        n_count      = r_count + {7'd0, idle_inc};
                    end else if (i_in_char == CH_BSLASH) begin
                        n_mode = MODE_WORD_ESC;
                    end else begin
                        o_entry.res0 = mk_char(i_in_char);
                        nres         = 2'd1;
                    end
                end
                MODE_WORD_ESC: begin
                    o_entry.res0 = mk_char(i_in_char);
                    nres         = 2'd1;
                    n_mode       = MODE_WORD;
                end
                MODE_DQ: begin
                    if (i_in_char == CH_DQUOTE) begin
                        o_entry.res0 = mk_end(KIND_WORD);
                        nres         = 2'd1;
                        n_mode       = MODE_IDLE;
                    end else if (i_in_char == CH_BSLASH) begin
                        n_mode = MODE_DQ_ESC;
                    end else begin
                        o_entry.res0 = mk_char(i_in_char);
                        nres         = 2'd1;
                    end
                end
                MODE_DQ_ESC: begin
                    o_entry.res0 = mk_char(i_in_char);
                    nres         = 2'd1;
                    n_mode       = MODE_DQ;
                end
                MODE_SQ: begin
                    if (i_in_char == CH_SQUOTE) begin
                        o_entry.res0 = mk_end(KIND_WORD);
                        nres         = 2'd1;
                        n_mode       = MODE_IDLE;
                    end else if (i_in_char == CH_BSLASH) begin
                        n_mode = MODE_SQ_ESC;
                    end else begin
                        o_entry.res0 = mk_char(i_in_char);
                        nres         = 2'd1;
                    end
                end
                MODE_SQ_ESC: begin
                    if (i_in_char == CH_SQUOTE) begin
                        o_entry.res0 = mk_char(i_in_char);
                        nres         = 2'd1;
                        n_mode       = MODE_SQ;
                    end else begin
                        // escape was literal, byte handled as quoted text
                        o_entry.res0 = mk_char(CH_BSLASH);
                        if (i_in_char == CH_BSLASH) begin
                            nres   = 2'd1;
                            n_mode = MODE_SQ_ESC;
                        end else begin
                            o_entry.res1 = mk_char(i_in_char);
                            nres         = 2'd2;
                            n_mode       = MODE_SQ;
                        end
                    end
                end
                MODE_GT: begin
                    if (i_in_char == CH_GT) begin
                        o_entry.res0 = mk_end(KIND_APPEND);
                        nres         = 2'd1;
                        n_mode       = MODE_IDLE;
                    end else begin
                        o_entry.res0 = mk_end(KIND_OUT);
                        o_entry.res1 = idle_res;
                        nres         = idle_has ? 2'd2 : 2'd1;
                        n_mode       = idle_mode;
                        n_count      = r_count + {7'd0, idle_inc};
                    end
                end
                MODE_DROP: begin
                    n_mode = MODE_DROP;
                end
                default: begin
                    o_entry.res0 = idle_res;
                    nres         = idle_has ? 2'd1 : 2'd0;
                    n_mode       = idle_mode;
                    n_count      = r_count + {7'd0, idle_inc};
                end
            endcase
        end
        o_entry.two = (nres == 2'd2);
    end

    assign o_push = accept && (nres != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_count     <= 8'd0;
            r_arg_slots <= DEF_ARG_SLOTS;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (i_cfg_wr_en) begin
                r_arg_slots <= i_cfg_wr_data;
            end
        end
    end

endmodule

/* src/slt_queue.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer entry queue
// Short FIFO of classified entries between front and back end.
// ----------------------------------------------------------------------------
`include "shell_line_tokenizer_unit_assert.svh"

module slt_queue #(
    parameter int unsigned DEPTH = slt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slt_pkg::t_entry    i_data,
    input  logic               i_pop,
    output slt_pkg::t_entry    o_head,
    output slt_pkg::t_q_status o_status
);
    import slt_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [IW-1:0]  r_wr, n_wr;
    logic [IW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + IW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + IW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SLT_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_status.full, !i_push)
    `SLT_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, o_status.empty, !i_pop)
    `SLT_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop,
                     r_count == $past(r_count) + CW'(1))

endmodule

/* src/slt_back.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer back end
// Unpacks queued entries into single results behind an output register.
// ----------------------------------------------------------------------------
`include "shell_line_tokenizer_unit_assert.svh"

module slt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slt_pkg::t_entry    i_head,
    input  slt_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_char,
    output logic               o_has_char,
    output logic               o_token_end,
    output logic [2:0]         o_token_kind,
    output logic               o_line_done,
    output logic               o_last
);
    import slt_pkg::*;

    logic    r_valid;
    logic    r_slot;
    t_result r_res;
    logic    r_line_done;
    logic    r_last;

    logic    out_free;
    logic    load;
    logic    final_slot;
    t_result sel_res;

    assign out_free   = !r_valid || !i_out_stall;
    assign load       = out_free && !i_q_status.empty;
    assign final_slot = r_slot || !i_head.two;
    assign sel_res    = r_slot ? i_head.res1 : i_head.res0;
    assign o_pop      = load && final_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 1'b0;
        end else begin
            if (out_free) begin
                r_valid <= !i_q_status.empty;
            end
            if (load) begin
                r_slot <= !final_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res       <= sel_res;
            r_last      <= final_slot;
            r_line_done <= final_slot && i_head.eol;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_char   = r_res.out_char;
    assign o_has_char   = r_res.has_char;
    assign o_token_end  = r_res.token_end;
    assign o_token_kind = r_res.token_kind;
    assign o_line_done  = r_line_done;
    assign o_last       = r_last;

    `SLT_ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, r_valid && r_line_done, r_last)
    `SLT_ASSERT_IMPL(a_char_not_end, i_clk, i_rst_n, r_valid && r_res.has_char,
                     !r_res.token_end && (r_res.token_kind == KIND_WORD))
    `SLT_ASSERT_IMPL(a_second_slot, i_clk, i_rst_n, r_slot, !i_q_status.empty && i_head.two)

endmodule

/* src/shell_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer
// Splits a command line, one byte per transfer, into word characters and
// token-end marks for words, quoted strings and redirect/pipe operators.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_in_char, i_end_of_line
//   out      output     o_out_valid / i_out_stall   char, flags, kind, last
//   cfg      input      i_cfg_wr_en                 i_cfg_wr_data (arg slots)
//
// One byte per cycle while the queue is not full; a byte giving two results
// leaves through the single back-end output register one result at a time.
// A result is presented once its byte has passed through the queue memory
// and the back-end output register.
// The queue absorbs output stalls; input stalls only when it is full.
// Synchronous reset: scan state idle, token count zero, arg slots 64.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_unit #(
    parameter int unsigned QUEUE_DEPTH = slt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_line,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_has_char,
    output logic       o_token_end,
    output logic [2:0] o_token_kind,
    output logic       o_line_done,
    output logic       o_last
);
    import slt_pkg::*;

    t_entry    push_entry;
    t_entry    head_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    slt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_char     (i_in_char),
        .i_end_of_line (i_end_of_line),
        .o_in_stall    (o_in_stall),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    slt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_entry),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_has_char   (o_has_char),
        .o_token_end  (o_token_end),
        .o_token_kind (o_token_kind),
        .o_line_done  (o_line_done),
        .o_last       (o_last)
    );

endmodule

/* test/shell_line_tokenizer_unit_test.sv */
// ----------------------------------------------------------------------------
// Shell line tokenizer testbench
// Feeds command lines byte by byte through the valid/stall input channel and
// checks every output transfer against a scoreboard that tracks scan mode,
// token count and the token limit. A short directed part comes first, then
// random well-formed lines with noise under several token limits, with bursty
// input and a changing output stall pattern.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_unit_test;

    import slt_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       tok_end;
        logic [2:0] kind;
        logic       line_done;
        logic       is_last;
    } tok_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } plan_item_t;

    class token_scoreboard;
        t_scan_mode  scan;
        logic [7:0]  tokens_seen;
        logic [7:0]  arg_limit;
        tok_result_t step_out[$];
        tok_result_t pending_results[$];
        int          errors;

        function new();
            arg_limit = DEF_ARG_SLOTS;
            errors    = 0;
            clear_line();
        endfunction

        function void clear_line();
            scan        = MODE_IDLE;
            tokens_seen = 8'd0;
        endfunction

        function void set_arg_slots(logic [7:0] v);
            arg_limit = v;
        endfunction

        function void put(logic [7:0] c, logic has, logic fin, t_token_kind k);
            tok_result_t r;
            r.ch        = has ? c : 8'd0;
            r.has_ch    = has;
            r.tok_end   = fin;
            r.kind      = k;
            r.line_done = 1'b0;
            r.is_last   = 1'b0;
            step_out.push_back(r);
        endfunction

        function void put_char(logic [7:0] c);
            put(c, 1'b1, 1'b0, KIND_WORD);
        endfunction

        function void put_end(t_token_kind k);
            put(8'd0, 1'b0, 1'b1, k);
        endfunction

        function bit is_space(logic [7:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit claim_slot();
            if ({1'b0, tokens_seen} + 9'd1 >= {1'b0, arg_limit}) begin
                scan = MODE_DROP;
                return 1'b0;
            end
            tokens_seen++;
            return 1'b1;
        endfunction

        function void between_tokens(logic [7:0] c);
            scan = MODE_IDLE;
            if (is_space(c)) return;
            if (!claim_slot()) return;
            case (c)
                CH_PIPE:   put_end(KIND_PIPE);
                CH_LT:     put_end(KIND_IN);
                CH_GT:     scan = MODE_GT;
                CH_DQUOTE: scan = MODE_DQ;
                CH_SQUOTE: scan = MODE_SQ;
                CH_BSLASH: scan = MODE_WORD_ESC;
                default: begin
                    put_char(c);
                    scan = MODE_WORD;
                end
            endcase
        endfunction

        function void in_single(logic [7:0] c);
            if (c == CH_SQUOTE) begin
                put_end(KIND_WORD);
                scan = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
                scan = MODE_SQ_ESC;
            end else begin
                put_char(c);
                scan = MODE_SQ;
            end
        endfunction

        function void flush_line();
            tok_result_t r;
            case (scan)
                MODE_WORD, MODE_DQ, MODE_SQ: put_end(KIND_WORD);
                MODE_WORD_ESC, MODE_DQ_ESC, MODE_SQ_ESC: begin
                    put_char(CH_BSLASH);
                    put_end(KIND_WORD);
                end
                MODE_GT: put_end(KIND_OUT);
                default: ;
            endcase
            if (step_out.size() == 0) put(8'd0, 1'b0, 1'b0, KIND_WORD);
            r           = step_out.pop_back();
            r.line_done = 1'b1;
            step_out.push_back(r);
            clear_line();
        endfunction

        function void note_byte(logic [7:0] c, logic eol);
            tok_result_t r;
            step_out.delete();
            if (eol) begin
                flush_line();
            end else begin
                case (scan)
                    MODE_WORD: begin
                        if (is_space(c)) begin
                            put_end(KIND_WORD);
                            scan = MODE_IDLE;
                        end else if (c == CH_PIPE || c == CH_LT || c == CH_GT) begin
                            put_end(KIND_WORD);
                            between_tokens(c);
                        end else if (c == CH_BSLASH) begin
                            scan = MODE_WORD_ESC;
                        end else begin
                            put_char(c);
                        end
                    end
                    MODE_WORD_ESC: begin
                        put_char(c);
                        scan = MODE_WORD;
                    end
                    MODE_DQ: begin
                        if (c == CH_DQUOTE) begin
                            put_end(KIND_WORD);
                            scan = MODE_IDLE;
                        end else if (c == CH_BSLASH) begin
                            scan = MODE_DQ_ESC;
                        end else begin
                            put_char(c);
                        end
                    end
                    MODE_DQ_ESC: begin
                        put_char(c);
                        scan = MODE_DQ;
                    end
                    MODE_SQ: in_single(c);
                    MODE_SQ_ESC: begin
                        if (c == CH_SQUOTE) begin
                            put_char(c);
                            scan = MODE_SQ;
                        end else begin
                            put_char(CH_BSLASH);
                            in_single(c);
                        end
                    end
                    MODE_GT: begin
                        if (c == CH_GT) begin
                            put_end(KIND_APPEND);
                            scan = MODE_IDLE;
                        end else begin
                            put_end(KIND_OUT);
                            between_tokens(c);
                        end
                    end
                    MODE_DROP: ;
                    default: between_tokens(c);
                endcase
            end
            if (step_out.size() != 0) begin
                r         = step_out.pop_back();
                r.is_last = 1'b1;
                step_out.push_back(r);
            end
            foreach (step_out[i]) pending_results.push_back(step_out[i]);
        endfunction

        function void check_result(tok_result_t got);
            tok_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: char %0h has %0b end %0b kind %0d",
                       got.ch, got.has_ch, got.tok_end, got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.ch !== want.ch) begin
                $error("out_char: expected %0h, actual %0h", want.ch, got.ch);
                errors++;
            end
            if (got.has_ch !== want.has_ch) begin
                $error("has_char: expected %0b, actual %0b", want.has_ch, got.has_ch);
                errors++;
            end
            if (got.tok_end !== want.tok_end) begin
                $error("token_end: expected %0b, actual %0b", want.tok_end, got.tok_end);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("token_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.line_done !== want.line_done) begin
                $error("line_done: expected %0b, actual %0b", want.line_done, got.line_done);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last: expected %0b, actual %0b", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_char     = 8'd0;
    logic       i_end_of_line = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_has_char;
    logic       o_token_end;
    logic [2:0] o_token_kind;
    logic       o_line_done;
    logic       o_last;

    token_scoreboard sb = new();
    plan_item_t      byte_plan[$];

    int stall_style = 0;
    int style_left  = 0;
    int stall_run   = 0;

    shell_line_tokenizer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_char     (i_in_char),
        .i_end_of_line (i_end_of_line),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_has_char    (o_has_char),
        .o_token_end   (o_token_end),
        .o_token_kind  (o_token_kind),
        .o_line_done   (o_line_done),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // receiver stall pattern: free, random, periodic or long holds
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(40, 300);
        end
        style_left--;
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            2: i_out_stall <= (style_left % 3 == 0);
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_run = $urandom_range(4, 15);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        tok_result_t got;
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_byte(i_in_char, i_end_of_line);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ch        = o_out_char;
            got.has_ch    = o_has_char;
            got.tok_end   = o_token_end;
            got.kind      = o_token_kind;
            got.line_done = o_line_done;
            got.is_last   = o_last;
            sb.check_result(got);
        end
    end

    function automatic void plan_byte(logic [7:0] c);
        plan_item_t it;
        it.ch  = c;
        it.eol = 1'b0;
        byte_plan.push_back(it);
    endfunction

    function automatic void plan_eol();
        plan_item_t it;
        it.ch  = 8'($urandom_range(0, 255));
        it.eol = 1'b1;
        byte_plan.push_back(it);
    endfunction

    function automatic void plan_text(string s);
        for (int i = 0; i < s.len(); i++) plan_byte(s[i]);
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_BSLASH ||
               c == CH_DQUOTE || c == CH_SQUOTE)
            c = 8'($urandom_range(33, 126));
        if ($urandom_range(0, 15) == 0) c = 8'($urandom_range(128, 255));
        return c;
    endfunction

    function automatic void plan_line();
        int         ntok;
        int         len;
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            repeat (len) plan_byte(8'($urandom_range(0, 255)));
            plan_eol();
            return;
        end
        ntok = $urandom_range(0, 7);
        repeat (ntok) begin
            if ($urandom_range(0, 4) != 0)
                plan_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 6);
                    repeat (len) begin
                        case ($urandom_range(0, 19))
                            0, 1: begin
                                plan_byte(CH_BSLASH);
                                plan_byte(8'($urandom_range(0, 255)));
                            end
                            2: plan_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                            default: plan_byte(word_char());
                        endcase
                    end
                end
                4: begin
                    plan_byte(CH_DQUOTE);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        if ($urandom_range(0, 5) == 0) begin
                            plan_byte(CH_BSLASH);
                            plan_byte(8'($urandom_range(0, 255)));
                        end else begin
                            c = 8'($urandom_range(0, 255));
                            if (c == CH_DQUOTE || c == CH_BSLASH) c = word_char();
                            plan_byte(c);
                        end
                    end
                    if ($urandom_range(0, 7) != 0) plan_byte(CH_DQUOTE);
                end
                5: begin
                    plan_byte(CH_SQUOTE);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        case ($urandom_range(0, 6))
                            0: begin
                                plan_byte(CH_BSLASH);
                                plan_byte(CH_SQUOTE);
                            end
                            1: begin
                                plan_byte(CH_BSLASH);
                                plan_byte(word_char());
                            end
                            default: begin
                                c = 8'($urandom_range(0, 255));
                                if (c == CH_SQUOTE || c == CH_BSLASH) c = word_char();
                                plan_byte(c);
                            end
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0) plan_byte(CH_SQUOTE);
                end
                6: plan_byte(CH_PIPE);
                7: plan_byte(CH_LT);
                8: plan_byte(CH_GT);
                default: begin
                    plan_byte(CH_GT);
                    plan_byte(CH_GT);
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0) plan_byte(CH_BSLASH);
        plan_eol();
    endfunction

    task automatic send_byte(plan_item_t it);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_in_char     <= it.ch;
        i_end_of_line <= it.eol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_char  <= 8'($urandom_range(0, 255));
        end
    endtask

    task automatic play_plan();
        int burst;
        while (byte_plan.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && byte_plan.size() != 0) begin
                send_byte(byte_plan.pop_front());
                burst--;
            end
            if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 6));
        end
    endtask

    task automatic wait_idle();
        gap(1);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_arg_slots(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_arg_slots(v);
    endtask

    // each phase pauses halfway until every pending result has come back
    task automatic run_phase(logic [7:0] arg_slots, int quota);
        write_arg_slots(arg_slots);
        while (byte_plan.size() < quota / 2) plan_line();
        play_plan();
        wait_idle();
        while (byte_plan.size() < quota - quota / 2) plan_line();
        play_plan();
        wait_idle();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan_text("a\"|<>>>x\t\"\\\"\"'\\'\\q'\"\"");
        plan_byte(8'h00);
        plan_byte(8'hFF);
        plan_eol();
        plan_eol();
        plan_byte(CH_SQUOTE);
        plan_eol();
        plan_byte(CH_BSLASH);
        plan_eol();
        plan_byte(CH_GT);
        plan_eol();
        play_plan();
        wait_idle();

        run_phase(8'd1, 14);
        run_phase(8'd2, 40);
        run_phase(8'd255, 56);
        run_phase(8'd0, 14);
        run_phase(8'd3, 40);
        run_phase(8'($urandom_range(4, 20)), 56);
        run_phase(DEF_ARG_SLOTS, 56);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* shell_line_tokenizer_unit.f */
+incdir+src
src/slt_pkg.sv
src/slt_front.sv
src/slt_queue.sv
src/slt_back.sv
src/shell_line_tokenizer_unit.sv
test/shell_line_tokenizer_unit_test.sv
